// ===== hdl/wgms_pkg.sv =====
// Package for the weighted group multicore scheduler.
// Holds the sequencer state type, request and error codes and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package wgms_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCHED_START,
    ST_DIV,
    ST_CHARGE_UPD,
    ST_SCHED_CLR,
    ST_PUSH_CHK,
    ST_PUSH_SCAN,
    ST_PUSH_ACT,
    ST_PUSH_WR,
    ST_PICK,
    ST_POP_RD,
    ST_POP_WAIT,
    ST_TICK_UPD,
    ST_DQ_CSCAN,
    ST_DQ_SRD,
    ST_DQ_SCMP,
    ST_DQ_SHRD,
    ST_DQ_SHWR,
    ST_DQ_CNT,
    ST_FIN
  } state_t;

  localparam logic [1:0] REQ_SCHED = 2'd0;
  localparam logic [1:0] REQ_ENQ   = 2'd1;
  localparam logic [1:0] REQ_DEQ   = 2'd2;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_FULL      = 2'd1;
  localparam logic [1:0] ERR_NOT_FOUND = 2'd2;

  localparam logic [15:0] TICK_RESET  = 16'd4000;
  localparam logic [15:0] BONUS_RESET = 16'd1000;

  localparam int VT_W    = 48;
  localparam int PROC_W  = 10;
  localparam int WGT_W   = 10;
  localparam int CNT_W   = 7;
  localparam int STAMP_W = 16;
  localparam int DIV_W   = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

  localparam logic [0:0] REG_TICK  = 1'b0;
  localparam logic [0:0] REG_BONUS = 1'b1;

endpackage

// ===== hdl/weighted_group_multicore_scheduler.sv =====
// Top level of the weighted group multicore scheduler: sequencer, group and
// core state, run stack memory and a shared bit-serial divider.
// Depends on wgms_pkg.
//
// Usage: requests arrive on the in_ stream (schedule, enqueue, dequeue), one
// result per request leaves on the out_ stream. Tick length and stay bonus are
// set through the APB-style cfg_ port while the block is idle.
// One request is worked on at a time; in_tready is high only in the idle state,
// in the cycle after each result is loaded. Enqueue passes dispatch, a check,
// a stack write and the result step, plus a scan over all groups and an
// activation step when the group is activated. Schedule on a busy core: two
// 32-step divisions of the shared divider, a pick scan over all groups and
// eight control steps. A requeue push adds a check and a write, plus a scan
// and an activation step when it activates the group. On an idle core the
// first division is skipped. With nothing to pick the result follows the scan
// directly. Dequeue adds a scan of up to CORES cores and a count step; a queued
// process costs a read and a compare per stack entry compared and a read and a
// write per entry moved through the single-port run stack memory.
// The result sits in an output register; a new request is accepted while it
// waits. A finished request holds in its last step while the receiver stalls.
// Reset clears activity, counts, stack lengths and busy flags; no clearing
// pass is needed.
`timescale 1ns / 1ps

module weighted_group_multicore_scheduler #(
  parameter int CORES       = 16,
  parameter int GROUPS      = 16,
  parameter int STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // req_type[1:0], core_id[5:2], pid[15:6], grp[19:16],
  // group_weight[29:20], is_new[30], ran_time[46:31], requeue_running[47]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // scheduled[0], chosen_process[10:1], chosen_group[14:11], grp_switch[15],
  // error_code[17:16], zero fill [23:18]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CIW = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int GIW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SIW = $clog2(STACK_DEPTH);
  localparam int LW  = $clog2(STACK_DEPTH + 1);
  localparam int RW  = $clog2(CORES + 1);
  localparam int AW  = GIW + SIW;
  localparam int VW  = wgms_pkg::VT_W;
  localparam int PW  = wgms_pkg::PROC_W;
  localparam int WW  = wgms_pkg::WGT_W;
  localparam int NW  = wgms_pkg::CNT_W;
  localparam int TW  = wgms_pkg::STAMP_W;
  localparam int DW  = wgms_pkg::DIV_W;

  // Input fields
  logic [1:0]  f_req;
  logic [3:0]  f_core;
  logic [PW-1:0] f_proc;
  logic [3:0]  f_group;
  logic [WW-1:0] f_wgt;
  logic        f_new;
  logic [15:0] f_tp;
  logic        f_rq;

  assign f_req   = in_tdata[1:0];
  assign f_core  = in_tdata[5:2];
  assign f_proc  = in_tdata[15:6];
  assign f_group = in_tdata[19:16];
  assign f_wgt   = in_tdata[29:20];
  assign f_new   = in_tdata[30];
  assign f_tp    = in_tdata[46:31];
  assign f_rq    = in_tdata[47];

  wgms_pkg::state_t state_r, state_nxt;

  logic [15:0] tick_r, bonus_r;

  // Request registers
  logic [1:0]    req_r;
  logic [CIW-1:0] c_r;
  logic          c_ok_r;
  logic [GIW-1:0] g_r;
  logic          g_ok_r;
  logic [PW-1:0] p_r;
  logic [WW-1:0] w_r;
  logic          new_r;
  logic [15:0]   tp_r;
  logic          rq_r;

  // Group state
  logic          grp_act_r   [GROUPS];
  logic [WW-1:0] grp_wgt_r   [GROUPS];
  logic [NW-1:0] grp_cnt_r   [GROUPS];
  logic [VW-1:0] grp_vt_r    [GROUPS];
  logic [TW-1:0] grp_stamp_r [GROUPS];
  logic [LW-1:0] grp_len_r   [GROUPS];
  logic [RW-1:0] grp_run_r   [GROUPS];
  logic [TW-1:0] act_ctr_r;

  // Core state
  logic          core_busy_r [CORES];
  logic [PW-1:0] core_proc_r [CORES];
  logic [GIW-1:0] core_grp_r [CORES];
  logic [DW-1:0] core_exp_r  [CORES];

  // Run stack memory
  logic [PW-1:0] stk_mem [2**AW];
  logic [PW-1:0] rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [PW-1:0] mem_wdata;

  // Sequencer working registers
  logic [CIW-1:0] cc_r;
  logic          had_r;
  logic [GIW-1:0] pg_r;
  logic [GIW-1:0] pu_g_r;
  logic [PW-1:0] pu_p_r;
  logic          pu_new_r;
  logic [WW-1:0] pu_w_r;
  logic          pu_sched_r;
  logic [GIW-1:0] idx_r;
  logic [CIW-1:0] cidx_r;
  logic          any_r;
  logic signed [VW-1:0] min_r;
  logic          found_r;
  logic [GIW-1:0] best_r;
  logic signed [VW:0] best_v_r;
  logic [TW-1:0] best_age_r;
  logic [DW-1:0] div_q_r;
  logic [WW-1:0] div_rem_r;
  logic [WW-1:0] div_dvs_r;
  logic [4:0]    div_cnt_r;
  logic          div_tick_r;
  logic [LW-1:0] k_r, j_r;
  logic          hit_r;

  logic          res_sched_r;
  logic [PW-1:0] res_proc_r;
  logic [GIW-1:0] res_grp_r;
  logic          res_chg_r;
  logic [1:0]    res_err_r;
  logic          out_valid_r;
  logic [23:0]   out_data_r;

  // Shared combinational terms
  logic          in_acc, out_acc, cfg_wr;
  logic          idx_last, cidx_last;
  logic          push_full;
  logic          dq_first_hit, dq_scan_hit;
  logic          pick_elig, pick_take;
  logic signed [VW:0] pick_eff;
  logic [TW-1:0] pick_age;
  logic          scan_take;
  logic [WW:0]   div_trial;
  logic          div_qbit;
  logic [LW-1:0] k_m1, pop_len;
  logic [LW:0]   j_p2;
  logic [NW-1:0] cnt_dec;
  logic [3:0]    res_grp_out;
  logic          fin_load;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_valid_r && out_tready;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign fin_load = (state_r == wgms_pkg::ST_FIN) && (!out_valid_r || out_tready);

  assign idx_last  = (idx_r == GIW'(GROUPS - 1));
  assign cidx_last = (cidx_r == CIW'(CORES - 1));
  assign push_full = (grp_len_r[pu_g_r] == LW'(STACK_DEPTH));

  assign dq_first_hit = c_ok_r && core_busy_r[c_r] && (core_proc_r[c_r] == p_r) &&
                        (core_grp_r[c_r] == g_r);
  assign dq_scan_hit  = core_busy_r[cidx_r] && (core_proc_r[cidx_r] == p_r) &&
                        (core_grp_r[cidx_r] == g_r);

  // Pick: one group per cycle, effective virtual time with the stay bonus.
  assign pick_elig = grp_act_r[idx_r] && (grp_len_r[idx_r] != '0) &&
                     (8'(grp_cnt_r[idx_r]) > 8'(grp_run_r[idx_r]));
  assign pick_eff  = $signed({grp_vt_r[idx_r][VW-1], grp_vt_r[idx_r]}) -
                     ((had_r && (idx_r == pg_r)) ?
                      $signed({17'd0, bonus_r, 16'd0}) : $signed((VW+1)'(0)));
  assign pick_age  = act_ctr_r - grp_stamp_r[idx_r];
  assign pick_take = pick_elig && (!found_r || (pick_eff < best_v_r) ||
                     ((pick_eff == best_v_r) && (pick_age < best_age_r)));

  // Activation: least virtual time of the other active groups.
  assign scan_take = (idx_r != pu_g_r) && grp_act_r[idx_r] &&
                     (!any_r || ($signed(grp_vt_r[idx_r]) < min_r));

  // Restoring divider step: the quotient shifts in where the dividend shifts out.
  assign div_trial = {div_rem_r, div_q_r[DW-1]};
  assign div_qbit  = (div_trial >= {1'b0, div_dvs_r});

  assign k_m1    = k_r - 1'b1;
  assign pop_len = grp_len_r[best_r] - 1'b1;
  assign j_p2    = (LW+1)'(j_r) + (LW+1)'(2);
  assign cnt_dec = (grp_cnt_r[g_r] != '0) ? grp_cnt_r[g_r] - 1'b1 : '0;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wgms_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = wgms_pkg::ST_DISPATCH;
      end
      wgms_pkg::ST_DISPATCH: begin
        case (req_r)
          wgms_pkg::REQ_SCHED:
            state_nxt = c_ok_r ? wgms_pkg::ST_SCHED_START : wgms_pkg::ST_FIN;
          wgms_pkg::REQ_ENQ:
            state_nxt = g_ok_r ? wgms_pkg::ST_PUSH_CHK : wgms_pkg::ST_FIN;
          wgms_pkg::REQ_DEQ: begin
            if (!g_ok_r) state_nxt = wgms_pkg::ST_FIN;
            else if (dq_first_hit) state_nxt = wgms_pkg::ST_DQ_CNT;
            else state_nxt = wgms_pkg::ST_DQ_CSCAN;
          end
          default: state_nxt = wgms_pkg::ST_FIN;
        endcase
      end
      wgms_pkg::ST_SCHED_START:
        state_nxt = core_busy_r[cc_r] ? wgms_pkg::ST_DIV : wgms_pkg::ST_SCHED_CLR;
      wgms_pkg::ST_DIV: begin
        if (div_cnt_r == 5'd31)
          state_nxt = div_tick_r ? wgms_pkg::ST_TICK_UPD : wgms_pkg::ST_CHARGE_UPD;
      end
      wgms_pkg::ST_CHARGE_UPD:
        state_nxt = rq_r ? wgms_pkg::ST_PUSH_CHK : wgms_pkg::ST_SCHED_CLR;
      wgms_pkg::ST_SCHED_CLR: state_nxt = wgms_pkg::ST_PICK;
      wgms_pkg::ST_PUSH_CHK: begin
        if (push_full)
          state_nxt = pu_sched_r ? wgms_pkg::ST_SCHED_CLR : wgms_pkg::ST_FIN;
        else if (grp_act_r[pu_g_r]) state_nxt = wgms_pkg::ST_PUSH_WR;
        else state_nxt = wgms_pkg::ST_PUSH_SCAN;
      end
      wgms_pkg::ST_PUSH_SCAN: begin
        if (idx_last) state_nxt = wgms_pkg::ST_PUSH_ACT;
      end
      wgms_pkg::ST_PUSH_ACT: state_nxt = wgms_pkg::ST_PUSH_WR;
      wgms_pkg::ST_PUSH_WR:
        state_nxt = pu_sched_r ? wgms_pkg::ST_SCHED_CLR : wgms_pkg::ST_FIN;
      wgms_pkg::ST_PICK: begin
        if (idx_last)
          state_nxt = (found_r || pick_take) ? wgms_pkg::ST_POP_RD : wgms_pkg::ST_FIN;
      end
      wgms_pkg::ST_POP_RD: state_nxt = wgms_pkg::ST_POP_WAIT;
      wgms_pkg::ST_POP_WAIT: state_nxt = wgms_pkg::ST_DIV;
      wgms_pkg::ST_TICK_UPD: state_nxt = wgms_pkg::ST_FIN;
      wgms_pkg::ST_DQ_CSCAN: begin
        if (dq_scan_hit) state_nxt = wgms_pkg::ST_DQ_CNT;
        else if (cidx_last)
          state_nxt = (grp_len_r[g_r] == '0) ? wgms_pkg::ST_FIN : wgms_pkg::ST_DQ_SRD;
      end
      wgms_pkg::ST_DQ_SRD: state_nxt = wgms_pkg::ST_DQ_SCMP;
      wgms_pkg::ST_DQ_SCMP: begin
        if (rd_data_r == p_r)
          state_nxt = (k_r < grp_len_r[g_r]) ? wgms_pkg::ST_DQ_SHRD : wgms_pkg::ST_DQ_CNT;
        else
          state_nxt = (k_r == LW'(1)) ? wgms_pkg::ST_FIN : wgms_pkg::ST_DQ_SRD;
      end
      wgms_pkg::ST_DQ_SHRD: state_nxt = wgms_pkg::ST_DQ_SHWR;
      wgms_pkg::ST_DQ_SHWR:
        state_nxt = (j_p2 < (LW+1)'(grp_len_r[g_r])) ? wgms_pkg::ST_DQ_SHRD :
                                                       wgms_pkg::ST_DQ_CNT;
      wgms_pkg::ST_DQ_CNT:
        state_nxt = hit_r ? wgms_pkg::ST_SCHED_START : wgms_pkg::ST_FIN;
      wgms_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) state_nxt = wgms_pkg::ST_IDLE;
      end
      default: state_nxt = wgms_pkg::ST_IDLE;
    endcase
  end

  // Outputs and memory port control
  always_comb begin
    in_tready = (state_r == wgms_pkg::ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = {pu_g_r, grp_len_r[pu_g_r][SIW-1:0]};
    mem_wdata = pu_p_r;
    mem_raddr = {best_r, pop_len[SIW-1:0]};
    case (state_r)
      wgms_pkg::ST_PUSH_WR: mem_we = 1'b1;
      wgms_pkg::ST_DQ_SRD:  mem_raddr = {g_r, k_m1[SIW-1:0]};
      wgms_pkg::ST_DQ_SHRD: mem_raddr = {g_r, SIW'(j_r + 1'b1)};
      wgms_pkg::ST_DQ_SHWR: begin
        mem_we    = 1'b1;
        mem_waddr = {g_r, j_r[SIW-1:0]};
        mem_wdata = rd_data_r;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) stk_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= stk_mem[mem_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == wgms_pkg::REG_BONUS) ? {16'd0, bonus_r} :
                                                             {16'd0, tick_r};
  assign res_grp_out = 4'(res_grp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wgms_pkg::ST_IDLE;
      tick_r      <= wgms_pkg::TICK_RESET;
      bonus_r     <= wgms_pkg::BONUS_RESET;
      act_ctr_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < GROUPS; i++) begin
        grp_act_r[i]   <= 1'b0;
        grp_cnt_r[i]   <= '0;
        grp_stamp_r[i] <= '0;
        grp_len_r[i]   <= '0;
        grp_run_r[i]   <= '0;
      end
      for (int i = 0; i < CORES; i++) core_busy_r[i] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (cfg_paddr[2] == wgms_pkg::REG_BONUS) bonus_r <= cfg_pwdata[15:0];
        else tick_r <= cfg_pwdata[15:0];
      end
      if (fin_load) out_valid_r <= 1'b1;
      else if (out_acc) out_valid_r <= 1'b0;

      case (state_r)
        wgms_pkg::ST_IDLE: begin
          if (in_acc) begin
            req_r  <= f_req;
            c_r    <= CIW'(f_core);
            c_ok_r <= (32'(f_core) < CORES);
            g_r    <= GIW'(f_group);
            g_ok_r <= (32'(f_group) < GROUPS);
            p_r    <= f_proc;
            w_r    <= f_wgt;
            new_r  <= f_new;
            tp_r   <= f_tp;
            rq_r   <= f_rq;
          end
        end
        wgms_pkg::ST_DISPATCH: begin
          res_sched_r <= 1'b0;
          res_proc_r  <= '0;
          res_grp_r   <= '0;
          res_chg_r   <= 1'b0;
          hit_r       <= (req_r == wgms_pkg::REQ_DEQ) && g_ok_r && dq_first_hit;
          cc_r        <= c_r;
          cidx_r      <= '0;
          pu_g_r      <= g_r;
          pu_p_r      <= p_r;
          pu_new_r    <= new_r;
          pu_w_r      <= w_r;
          pu_sched_r  <= 1'b0;
          if (req_r == wgms_pkg::REQ_DEQ) rq_r <= 1'b0;
          if (((req_r == wgms_pkg::REQ_SCHED) && !c_ok_r) ||
              (((req_r == wgms_pkg::REQ_ENQ) || (req_r == wgms_pkg::REQ_DEQ)) && !g_ok_r))
            res_err_r <= wgms_pkg::ERR_NOT_FOUND;
          else
            res_err_r <= wgms_pkg::ERR_OK;
        end
        wgms_pkg::ST_SCHED_START: begin
          had_r      <= core_busy_r[cc_r];
          pg_r       <= core_grp_r[cc_r];
          div_q_r    <= {tp_r, 16'd0};
          div_rem_r  <= '0;
          div_dvs_r  <= (grp_wgt_r[core_grp_r[cc_r]] == '0) ? WW'(1) :
                        grp_wgt_r[core_grp_r[cc_r]];
          div_cnt_r  <= '0;
          div_tick_r <= 1'b0;
        end
        wgms_pkg::ST_DIV: begin
          div_rem_r <= div_qbit ? WW'(div_trial - {1'b0, div_dvs_r}) : WW'(div_trial);
          div_q_r   <= {div_q_r[DW-2:0], div_qbit};
          div_cnt_r <= div_cnt_r + 1'b1;
        end
        wgms_pkg::ST_CHARGE_UPD: begin
          grp_vt_r[pg_r] <= grp_vt_r[pg_r] + VW'(div_q_r) - VW'(core_exp_r[cc_r]);
          pu_g_r     <= pg_r;
          pu_p_r     <= core_proc_r[cc_r];
          pu_new_r   <= 1'b0;
          pu_w_r     <= grp_wgt_r[pg_r];
          pu_sched_r <= 1'b1;
        end
        wgms_pkg::ST_SCHED_CLR: begin
          if (had_r) begin
            core_busy_r[cc_r] <= 1'b0;
            grp_run_r[pg_r]   <= grp_run_r[pg_r] - 1'b1;
          end
          idx_r   <= '0;
          found_r <= 1'b0;
        end
        wgms_pkg::ST_PUSH_CHK: begin
          if (push_full) res_err_r <= wgms_pkg::ERR_FULL;
          idx_r <= '0;
          any_r <= 1'b0;
        end
        wgms_pkg::ST_PUSH_SCAN: begin
          if (scan_take) begin
            any_r <= 1'b1;
            min_r <= $signed(grp_vt_r[idx_r]);
          end
          idx_r <= idx_r + 1'b1;
        end
        wgms_pkg::ST_PUSH_ACT: begin
          grp_vt_r[pu_g_r]    <= any_r ? VW'(min_r) : '0;
          grp_wgt_r[pu_g_r]   <= (pu_w_r == '0) ? WW'(1) : pu_w_r;
          act_ctr_r           <= act_ctr_r + 1'b1;
          grp_stamp_r[pu_g_r] <= act_ctr_r + 1'b1;
          grp_act_r[pu_g_r]   <= 1'b1;
        end
        wgms_pkg::ST_PUSH_WR: begin
          grp_len_r[pu_g_r] <= grp_len_r[pu_g_r] + 1'b1;
          if (pu_new_r && (grp_cnt_r[pu_g_r] < wgms_pkg::CNT_MAX))
            grp_cnt_r[pu_g_r] <= grp_cnt_r[pu_g_r] + 1'b1;
        end
        wgms_pkg::ST_PICK: begin
          if (pick_take) begin
            found_r    <= 1'b1;
            best_r     <= idx_r;
            best_v_r   <= pick_eff;
            best_age_r <= pick_age;
          end
          idx_r <= idx_r + 1'b1;
        end
        wgms_pkg::ST_POP_RD: grp_len_r[best_r] <= pop_len;
        wgms_pkg::ST_POP_WAIT: begin
          core_busy_r[cc_r] <= 1'b1;
          core_proc_r[cc_r] <= rd_data_r;
          core_grp_r[cc_r]  <= best_r;
          grp_run_r[best_r] <= grp_run_r[best_r] + 1'b1;
          res_sched_r <= 1'b1;
          res_proc_r  <= rd_data_r;
          res_grp_r   <= best_r;
          res_chg_r   <= !had_r || (pg_r != best_r);
          div_q_r     <= {tick_r, 16'd0};
          div_rem_r   <= '0;
          div_dvs_r   <= (grp_wgt_r[best_r] == '0) ? WW'(1) : grp_wgt_r[best_r];
          div_cnt_r   <= '0;
          div_tick_r  <= 1'b1;
        end
        wgms_pkg::ST_TICK_UPD: begin
          core_exp_r[cc_r]  <= div_q_r;
          grp_vt_r[best_r]  <= grp_vt_r[best_r] + VW'(div_q_r);
        end
        wgms_pkg::ST_DQ_CSCAN: begin
          if (dq_scan_hit) begin
            hit_r <= 1'b1;
            cc_r  <= cidx_r;
          end else if (cidx_last) begin
            k_r <= grp_len_r[g_r];
            if (grp_len_r[g_r] == '0) res_err_r <= wgms_pkg::ERR_NOT_FOUND;
          end
          cidx_r <= cidx_r + 1'b1;
        end
        wgms_pkg::ST_DQ_SCMP: begin
          if (rd_data_r == p_r) j_r <= k_m1;
          else begin
            k_r <= k_m1;
            if (k_r == LW'(1)) res_err_r <= wgms_pkg::ERR_NOT_FOUND;
          end
        end
        wgms_pkg::ST_DQ_SHWR: j_r <= j_r + 1'b1;
        wgms_pkg::ST_DQ_CNT: begin
          grp_cnt_r[g_r] <= cnt_dec;
          if (!hit_r) grp_len_r[g_r] <= grp_len_r[g_r] - 1'b1;
          if (cnt_dec == '0) begin
            grp_act_r[g_r] <= 1'b0;
            // A running process whose group goes inactive leaves the core
            // without any charge.
            if (hit_r) begin
              core_busy_r[cc_r] <= 1'b0;
              grp_run_r[g_r]    <= grp_run_r[g_r] - 1'b1;
            end
          end
        end
        wgms_pkg::ST_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {6'd0, res_err_r, res_chg_r, res_grp_out, res_proc_r,
                            res_sched_r};
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
